// ----- rtl/ffsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

    localparam int ADDR_BITS = 16;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_ZERO     = 3'd4
    } t_status;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_CARVE,
        S_MRG_RD,
        S_MRG_CHK,
        S_CMP_RD,
        S_CMP_WR,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/ffsa_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ffsa_in_if;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [15:0]          request_size;
    logic [15:0]          address;
    modport source (output valid, mode, request_size, address, input ready);
    modport sink   (input valid, mode, request_size, address, output ready);
endinterface

interface ffsa_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] alloc_address;
    logic [2:0]  status;
    modport source (output valid, alloc_address, status, input ready);
    modport sink   (input valid, alloc_address, status, output ready);
endinterface

interface ffsa_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/ffsa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/first_fit_segment_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Beat payload
// s_in      in   mode, request_size, address
// m_out     out  alloc_address, status
// s_cfg     in   pool_size
//
// One item at a time: a scan reads and checks each entry visited, an allocate
// shift reads and writes each entry moved, and a free reads and writes each
// entry moved for each entry it absorbs; the segment RAM has one read port.
// Worst case is a free absorbing a table-long run of free entries.
// Reset and a pool_size write restore one free segment; no clearing pass.
// Output is held in a register until taken; no new item until then.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ffsa_in_if.sink    s_in,
    ffsa_out_if.source m_out,
    ffsa_cfg_if.sink   s_cfg
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = 2 * ADDR_BITS + 1;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;   // scan / found entry
    logic [CW-1:0] r_k, n_k;       // shift / compact pointer
    logic          r_mode;
    logic [ADDR_BITS-1:0] r_req, r_addr;
    logic [ADDR_BITS-1:0] r_pool;
    logic [EW-1:0] r_hold, n_hold;  // entry held for merge/carve
    logic [15:0]   r_oaddr, n_oaddr;
    logic [2:0]    r_ost, n_ost;
    logic          r_ovalid, n_ovalid;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    // entry layout {free, size, start}
    logic                 rd_free;
    logic [ADDR_BITS-1:0] rd_size, rd_start;
    assign rd_free  = rdata[EW-1];
    assign rd_size  = rdata[2*ADDR_BITS-1:ADDR_BITS];
    assign rd_start = rdata[ADDR_BITS-1:0];

    logic cfg_go;
    assign cfg_go      = s_cfg.valid && s_cfg.ready;
    assign s_cfg.ready = (r_state == S_IDLE) && !r_ovalid;
    assign s_in.ready  = (r_state == S_IDLE) && !r_ovalid && !s_cfg.valid;
    assign m_out.valid = r_ovalid;
    assign m_out.alloc_address = r_oaddr;
    assign m_out.status = r_ost;

    logic [CW-1:0] idx_w;
    assign idx_w = r_idx;

    always_comb begin
        n_state = r_state; n_count = r_count; n_idx = r_idx; n_k = r_k;
        n_hold = r_hold; n_oaddr = r_oaddr; n_ost = r_ost;
        n_ovalid = r_ovalid;
        if (m_out.valid && m_out.ready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_in.valid && s_in.ready) begin
                    n_idx = '0;
                    n_oaddr = '0;
                    if (s_in.mode == MODE_ALLOC && s_in.request_size == 16'd0) begin
                        n_ost = ST_ZERO;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (idx_w >= r_count) begin
                    n_ost = (r_mode == MODE_FREE) ? ST_NOTFOUND : ST_NOFIT;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                n_hold = rdata;
                if (r_mode == MODE_ALLOC) begin
                    if (rd_free && rd_size >= r_req) begin
                        if (r_count >= CW'(MAX_SEGMENTS)) begin
                            n_ost = ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_k = r_count;
                            n_state = S_SHIFT_RD;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end else if (rd_start == r_addr) begin
                    n_hold = {1'b1, rd_size, rd_start};
                    n_state = S_MRG_RD;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (r_k > idx_w + 1'b1) n_state = S_SHIFT_WR;
                else n_state = S_CARVE;
            end
            S_SHIFT_WR: begin
                n_k = r_k - 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_CARVE: begin
                n_count = r_count + 1'b1;
                n_oaddr = 16'(r_hold[ADDR_BITS-1:0]);
                n_ost = ST_OK;
                n_state = S_DONE;
            end
            S_MRG_RD: begin
                if (idx_w + 1'b1 < r_count) n_state = S_MRG_CHK;
                else begin
                    n_ost = ST_OK;
                    n_state = S_DONE;
                end
            end
            S_MRG_CHK: begin
                if (rd_free) begin
                    n_hold[2*ADDR_BITS-1:ADDR_BITS] =
                        r_hold[2*ADDR_BITS-1:ADDR_BITS] + rd_size;
                    n_k = idx_w + 1'b1;
                    n_state = S_CMP_RD;
                end else begin
                    n_ost = ST_OK;
                    n_state = S_DONE;
                end
            end
            S_CMP_RD: begin
                if (r_k + 1'b1 < r_count) n_state = S_CMP_WR;
                else begin
                    n_count = r_count - 1'b1;
                    n_state = S_MRG_RD;
                end
            end
            S_CMP_WR: begin
                n_k = r_k + 1'b1;
                n_state = S_CMP_RD;
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM port control
    always_comb begin
        we = 1'b0; waddr = IW'(r_idx); wdata = r_hold; raddr = IW'(r_idx);
        case (r_state)
            S_IDLE: begin
                if (cfg_go) begin
                    we = 1'b1; waddr = '0;
                    wdata = {1'b1, ADDR_BITS'(s_cfg.data), ADDR_BITS'(0)};
                end
            end
            S_SHIFT_RD: raddr = IW'(r_k - 1'b1);
            S_SHIFT_WR: begin
                we = 1'b1; waddr = IW'(r_k); wdata = rdata;
            end
            S_CARVE: begin
                we = 1'b1; waddr = IW'(r_idx);
                wdata = {1'b0, r_req, r_hold[ADDR_BITS-1:0]};
            end
            S_MRG_RD: begin
                raddr = IW'(idx_w + 1'b1);
                we = 1'b1; waddr = IW'(r_idx); wdata = r_hold;
            end
            S_CMP_RD: raddr = IW'(r_k + 1'b1);
            S_CMP_WR: begin
                we = 1'b1; waddr = IW'(r_k); wdata = rdata;
            end
            default: ;
        endcase
    end

    // free remainder goes in above the carved entry during the DONE cycle
    logic rem_we;
    assign rem_we = (r_state == S_DONE) && (r_mode == MODE_ALLOC) && (r_ost == ST_OK);

    logic          we2;
    logic [IW-1:0] waddr2;
    logic [EW-1:0] wdata2;
    always_comb begin
        we2 = we; waddr2 = waddr; wdata2 = wdata;
        if (rem_we) begin
            we2 = 1'b1;
            waddr2 = IW'(idx_w + 1'b1);
            wdata2 = {1'b1, r_hold[2*ADDR_BITS-1:ADDR_BITS] - r_req,
                      r_hold[ADDR_BITS-1:0] + r_req};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CW'(1);
            r_ovalid <= 1'b0;
            r_pool <= ADDR_BITS'(16'hFFFF);
        end else begin
            r_state <= n_state;
            r_count <= cfg_go ? CW'(1) : n_count;
            r_ovalid <= n_ovalid;
            if (cfg_go) r_pool <= ADDR_BITS'(s_cfg.data);
        end
        r_idx <= n_idx; r_k <= n_k; r_hold <= n_hold;
        r_oaddr <= n_oaddr; r_ost <= n_ost;
        if (s_in.valid && s_in.ready) begin
            r_mode <= s_in.mode;
            r_req  <= ADDR_BITS'(s_in.request_size);
            r_addr <= ADDR_BITS'(s_in.address);
        end
    end

    // entry 0 after reset is rewritten on the first cycle out of reset
    logic r_init;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_init <= 1'b1;
        else r_init <= 1'b0;
    end

    logic          we_f;
    logic [IW-1:0] waddr_f;
    logic [EW-1:0] wdata_f;
    always_comb begin
        we_f = we2; waddr_f = waddr2; wdata_f = wdata2;
        if (r_init && !cfg_go) begin
            we_f = 1'b1; waddr_f = '0;
            wdata_f = {1'b1, r_pool, ADDR_BITS'(0)};
        end
    end

    ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk(i_clk), .i_we(we_f), .i_waddr(waddr_f), .i_wdata(wdata_f),
        .i_raddr(raddr), .o_rdata(rdata)
    );
endmodule
`default_nettype wire

// ----- tb/tb_first_fit_segment_allocator.sv -----
`timescale 1ns / 1ps
module tb_first_fit_segment_allocator;
    import ffsa_pkg::*;

    localparam int NSEG  = 64;
    localparam int LIMIT = 20_000_000;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_size;
        logic [15:0] address;
    } req_t;

    typedef struct packed {
        logic [15:0] alloc_address;
        t_status     status;
    } resp_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ffsa_in_if  in_ch ();
    ffsa_out_if out_ch ();
    ffsa_cfg_if cfg_ch ();

    first_fit_segment_allocator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (in_ch.sink),
        .m_out  (out_ch.source),
        .s_cfg  (cfg_ch.sink)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow segment table
    logic [15:0] tbl_start [NSEG];
    logic [15:0] tbl_size  [NSEG];
    logic        tbl_free  [NSEG];
    int          tbl_count;

    req_t  pending_reqs [$];
    resp_t expected_resp [$];
    int    fail_count = 0;
    int    cycle_count = 0;
    bit    stim_done = 1'b0;
    bit    hold_send = 1'b0;

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic void table_reset(input logic [15:0] pool);
        for (int i = 0; i < NSEG; i++) begin
            tbl_start[i] = '0;
            tbl_size[i]  = '0;
            tbl_free[i]  = 1'b0;
        end
        tbl_size[0] = pool;
        tbl_free[0] = 1'b1;
        tbl_count   = 1;
    endfunction

    function automatic resp_t allocate_or_free(input req_t r);
        resp_t res;
        int i;
        res.alloc_address = '0;
        res.status = ST_OK;
        if (r.mode == MODE_ALLOC) begin
            if (r.request_size == 0) begin
                res.status = ST_ZERO;
                return res;
            end
            for (i = 0; i < tbl_count; i++)
                if (tbl_free[i] && tbl_size[i] >= r.request_size) break;
            if (i >= tbl_count) begin
                res.status = ST_NOFIT;
                return res;
            end
            if (tbl_count >= NSEG) begin
                res.status = ST_FULL;
                return res;
            end
            for (int k = tbl_count; k > i + 1; k--) begin
                tbl_start[k] = tbl_start[k-1];
                tbl_size[k]  = tbl_size[k-1];
                tbl_free[k]  = tbl_free[k-1];
            end
            tbl_start[i+1] = tbl_start[i] + r.request_size;
            tbl_size[i+1]  = tbl_size[i] - r.request_size;
            tbl_free[i+1]  = 1'b1;
            tbl_size[i]    = r.request_size;
            tbl_free[i]    = 1'b0;
            tbl_count++;
            res.alloc_address = tbl_start[i];
        end else begin
            for (i = 0; i < tbl_count; i++)
                if (tbl_start[i] == r.address) break;
            if (i >= tbl_count) begin
                res.status = ST_NOTFOUND;
                return res;
            end
            tbl_free[i] = 1'b1;
            while (i + 1 < tbl_count && tbl_free[i+1]) begin
                tbl_size[i] = tbl_size[i] + tbl_size[i+1];
                for (int k = i + 1; k + 1 < tbl_count; k++) begin
                    tbl_start[k] = tbl_start[k+1];
                    tbl_size[k]  = tbl_size[k+1];
                    tbl_free[k]  = tbl_free[k+1];
                end
                tbl_count--;
            end
        end
        return res;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // input driver
    int  send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid        <= 1'b0;
            in_ch.mode         <= 1'b0;
            in_ch.request_size <= '0;
            in_ch.address      <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_resp.push_back(allocate_or_free(pending_reqs.pop_front()));
                send_gap = gap_len();
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !hold_send) begin
                    in_ch.valid        <= 1'b1;
                    in_ch.mode         <= pending_reqs[0].mode;
                    in_ch.request_size <= pending_reqs[0].request_size;
                    in_ch.address      <= pending_reqs[0].address;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_resp.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    resp_t e;
                    e = expected_resp.pop_front();
                    if (out_ch.alloc_address !== e.alloc_address)
                        report($sformatf("alloc_address %0d, expected %0d",
                               out_ch.alloc_address, e.alloc_address));
                    if (out_ch.status !== e.status)
                        report($sformatf("status %0d, expected %0d",
                               out_ch.status, e.status));
                end
                recv_gap = gap_len();
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_resp.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic write_pool(input logic [15:0] pool);
        cfg_ch.data  <= pool;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        table_reset(pool);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void push(input logic m, input logic [15:0] sz,
                                 input logic [15:0] ad);
        req_t r;
        r.mode = m;
        r.request_size = sz;
        r.address = ad;
        pending_reqs.push_back(r);
    endfunction

    // half allocs, mostly of small sizes so the table fills, half frees, mostly at small addresses
    task automatic random_phase(input int n);
        for (int j = 0; j < n; j++) begin
            int p;
            p = $urandom_range(99);
            if (p < 50) begin
                if ($urandom_range(9) == 0) push(MODE_ALLOC, 16'($urandom()), 16'($urandom()));
                else push(MODE_ALLOC, 16'($urandom_range(40, 0)), 16'($urandom()));
            end else if (p < 90) begin
                push(MODE_FREE, 16'($urandom()),
                     16'($urandom_range(20) * $urandom_range(40)));
            end else begin
                push(MODE_FREE, 16'($urandom()), 16'($urandom()));
            end
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.request_size = '0;
        in_ch.address = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        table_reset(16'hFFFF);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero size, no fit, unknown free
        push(MODE_ALLOC, 16'd0, 16'hFFFF);
        push(MODE_ALLOC, 16'hFFFF, 16'd0);
        push(MODE_ALLOC, 16'd1, 16'd0);
        push(MODE_FREE, 16'hFFFF, 16'd0);
        push(MODE_FREE, 16'd0, 16'd0);
        push(MODE_FREE, 16'd0, 16'hFFFF);
        push(MODE_ALLOC, 16'd100, 16'd0);
        push(MODE_ALLOC, 16'd200, 16'd0);
        push(MODE_FREE, 16'd0, 16'd100);
        push(MODE_FREE, 16'd0, 16'd0);
        wait_idle();

        write_pool(16'd0);
        push(MODE_ALLOC, 16'd1, 16'd0);
        push(MODE_FREE, 16'd0, 16'd0);
        wait_idle();

        write_pool(16'd100);
        for (int j = 0; j < 12; j++) push(MODE_ALLOC, 16'd1, 16'd0);
        push(MODE_ALLOC, 16'd88, 16'd0);
        push(MODE_ALLOC, 16'd1, 16'd0);
        wait_idle();

        write_pool(16'd1);
        random_phase(300);
        wait_idle();

        write_pool(16'd65535);
        random_phase(400);
        // part way through, the sender holds back until the block has drained
        while (pending_reqs.size() > 200) @(posedge i_clk);
        hold_send = 1'b1;
        while (expected_resp.size() > 0 || in_ch.valid) @(posedge i_clk);
        hold_send = 1'b0;
        wait_idle();

        write_pool(16'd600);
        random_phase(400);
        wait_idle();

        write_pool(16'($urandom_range(65535, 1)));
        random_phase(400);
        wait_idle();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
